// ===== rtl/tss_pkg.sv =====
// Shared constants, types and codes of the target share selector.
package tss_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int COUNT_BITS  = 32;

    localparam int OP_W    = 2;
    localparam int TYPE_W  = 32;
    localparam int TGT_W   = 7;
    localparam int START_W = 3;

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int USED_W = $clog2(MAX_ENTRIES + 1);
    localparam int MOD_W  = (USED_W > START_W) ? USED_W : START_W;

    // share = count * 100 / total; 100 fits in TGT_W bits
    localparam int PCT_SCALE = 100;
    localparam int PROD_W    = COUNT_BITS + TGT_W;
    localparam int DCNT_W    = $clog2(PROD_W + 1);

    localparam logic [TGT_W-1:0] TGT_CLAMP = TGT_W'(PCT_SCALE);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_PICK   = 2'd2,
        OP_EXISTS = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_MOD,
        S_RD,
        S_MUL,
        S_DIV,
        S_CMP,
        S_WIN,
        S_INC,
        S_LRD,
        S_LCMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             we_entry;
        logic             we_count;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] raddr;
    } t_tbl_ctl;

endpackage

// ===== rtl/tss_if.sv =====
// Valid/ready channel interfaces for the command and result transactions.
interface tss_in_if;
    import tss_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     opcode;
    logic [TYPE_W-1:0]   entry_type;
    logic [TGT_W-1:0]    target_percent;
    logic [START_W-1:0]  tie_start;

    modport source (output valid, output opcode, output entry_type,
                    output target_percent, output tie_start, input ready);
    modport sink   (input valid, input opcode, input entry_type,
                    input target_percent, input tie_start, output ready);
endinterface

interface tss_out_if;
    import tss_pkg::*;

    logic              valid;
    logic              ready;
    logic [TYPE_W-1:0] chosen_type;
    logic              hit;
    logic              table_full;

    modport source (output valid, output chosen_type, output hit,
                    output table_full, input ready);
    modport sink   (input valid, input chosen_type, input hit,
                    input table_full, output ready);
endinterface

// ===== rtl/target_share_selector_top.sv =====
// Top level of the target share selector: sequencer around the shared divider.
//
// Usage:
//   i_in carries one command transaction (opcode, entry_type, target_percent,
//   tie_start); o_out returns exactly one result transaction (chosen_type,
//   hit, table_full) per command, in order. Both are valid/ready channels.
//   The block takes one command at a time: i_in.ready is high only while the
//   sequencer is idle, and a finished result sits in an output register so
//   the next command is taken while that result still waits.
// Steps per command:
//   clear, dropped add: straight to the result; add: one table write.
//   exists           : a read and a compare per entry scanned, up to a match.
//   pick             : tie_start reduction, then per entry a table read,
//                      the product and a division (skipped while the total
//                      is zero) and a compare; the winner's count and the
//                      total then go up. Each entry's share goes through
//                      the one restoring divider.
// Reset (synchronous, active low) empties the table and zeroes the total
// pick count; entry contents are not cleared and are only read once added.
// When o_out stalls, the result holds and a completed command waits in its
// final state until the output register frees up.
module target_share_selector_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tss_in_if.sink    i_in,
    tss_out_if.source o_out
);
    import tss_pkg::*;

    t_state                r_state;
    t_state                n_state;

    logic [TYPE_W-1:0]     r_type;
    logic [TGT_W-1:0]      r_tgt;
    logic [USED_W-1:0]     r_used;
    logic [USED_W-1:0]     r_k;
    logic [COUNT_BITS-1:0] r_total;
    logic [MOD_W-1:0]      r_mod;
    logic [IDX_W-1:0]      r_idx;

    logic [PROD_W-1:0]     r_share;
    logic [TGT_W-1:0]      r_cur_tgt;
    logic [IDX_W-1:0]      r_best_idx;
    logic [PROD_W-1:0]     r_best_share;
    logic [TGT_W-1:0]      r_best_tgt;
    logic                  r_best_wanted;

    logic [TYPE_W-1:0]     r_res_type;
    logic                  r_res_hit;
    logic                  r_res_full;

    logic                  r_out_valid;
    logic [TYPE_W-1:0]     r_out_type;
    logic                  r_out_hit;
    logic                  r_out_full;

    // table and divider hookup
    t_tbl_ctl              tbl_ctl;
    logic [COUNT_BITS-1:0] tbl_wcount;
    logic [TGT_W-1:0]      tbl_wtgt;
    logic [TYPE_W-1:0]     rd_type;
    logic [TGT_W-1:0]      rd_tgt;
    logic [COUNT_BITS-1:0] rd_count;
    logic                  div_start;
    logic                  div_done;
    logic [PROD_W-1:0]     div_q;
    logic [PROD_W-1:0]     product;

    logic                  in_fire;
    logic                  in_ready;
    logic                  out_free;
    logic                  last_entry;
    logic                  table_is_full;
    logic                  cand_wanted;
    logic                  cand_better;
    logic [COUNT_BITS-1:0] count_inc;
    logic [IDX_W-1:0]      idx_wrap;

    // true when candidate a beats the current best b
    function automatic logic f_better(
        input logic              wa,
        input logic [PROD_W-1:0] sa,
        input logic [TGT_W-1:0]  ta,
        input logic              wb,
        input logic [PROD_W-1:0] sb,
        input logic [TGT_W-1:0]  tb
    );
        logic res;
        if (wa != wb) begin
            res = wa;
        end else if (sa != sb) begin
            res = sa < sb;
        end else begin
            res = wa && (ta > tb);
        end
        return res;
    endfunction

    assign in_ready      = (r_state == S_IDLE);
    assign in_fire       = i_in.valid && in_ready;
    assign out_free      = !r_out_valid || o_out.ready;
    assign last_entry    = (r_k + USED_W'(1)) == r_used;
    assign table_is_full = (r_used == USED_W'(MAX_ENTRIES));
    assign cand_wanted   = (r_cur_tgt != '0) && (r_share <= PROD_W'(r_cur_tgt));
    assign cand_better   = f_better(cand_wanted, r_share, r_cur_tgt,
                                    r_best_wanted, r_best_share, r_best_tgt);
    assign count_inc     = (rd_count == '1) ? rd_count : rd_count + COUNT_BITS'(1);
    assign idx_wrap      = ((USED_W'(r_idx) + USED_W'(1)) == r_used) ?
                           '0 : r_idx + IDX_W'(1);
    assign product       = PROD_W'(rd_count) * PROD_W'(PCT_SCALE);
    assign tbl_wtgt      = (r_tgt > TGT_CLAMP) ? TGT_CLAMP : r_tgt;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (t_opcode'(i_in.opcode))
                        OP_CLEAR:  n_state = S_DONE;
                        OP_ADD:    n_state = table_is_full ? S_DONE : S_ADD;
                        OP_PICK:   n_state = (r_used == '0) ? S_DONE : S_MOD;
                        OP_EXISTS: n_state = (r_used == '0) ? S_DONE : S_LRD;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_ADD:  n_state = S_DONE;
            S_MOD:  n_state = (r_mod >= MOD_W'(r_used)) ? S_MOD : S_RD;
            S_RD:   n_state = S_MUL;
            S_MUL:  n_state = (r_total == '0) ? S_CMP : S_DIV;
            S_DIV:  n_state = div_done ? S_CMP : S_DIV;
            S_CMP:  n_state = last_entry ? S_WIN : S_RD;
            S_WIN:  n_state = S_INC;
            S_INC:  n_state = S_DONE;
            S_LRD:  n_state = S_LCMP;
            S_LCMP: n_state = ((rd_type == r_type) || last_entry) ? S_DONE : S_LRD;
            S_DONE: n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // table and divider controls
    always_comb begin
        tbl_ctl.we_entry = 1'b0;
        tbl_ctl.we_count = 1'b0;
        tbl_ctl.waddr    = r_best_idx;
        tbl_ctl.raddr    = r_idx;
        tbl_wcount       = count_inc;
        div_start        = 1'b0;
        case (r_state)
            S_ADD: begin
                tbl_ctl.we_entry = 1'b1;
                tbl_ctl.waddr    = r_used[IDX_W-1:0];
                tbl_wcount       = '0;
            end
            S_MUL:   div_start        = (r_total != '0);
            S_WIN:   tbl_ctl.raddr    = r_best_idx;
            S_INC:   tbl_ctl.we_count = 1'b1;
            default: tbl_ctl.raddr    = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // drop the result once taken, unless a new one loads below
            if (r_out_valid && o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_type     <= i_in.entry_type;
                        r_tgt      <= i_in.target_percent;
                        r_mod      <= MOD_W'(i_in.tie_start);
                        r_idx      <= '0;
                        r_k        <= '0;
                        r_res_type <= '0;
                        r_res_hit  <= 1'b0;
                        r_res_full <= (t_opcode'(i_in.opcode) == OP_ADD) && table_is_full;
                        if (t_opcode'(i_in.opcode) == OP_CLEAR) begin
                            r_used  <= '0;
                            r_total <= '0;
                        end
                    end
                end
                S_ADD: r_used <= r_used + USED_W'(1);
                S_MOD: begin
                    // reduce tie_start modulo the entry count
                    if (r_mod >= MOD_W'(r_used)) begin
                        r_mod <= r_mod - MOD_W'(r_used);
                    end else begin
                        r_idx <= r_mod[IDX_W-1:0];
                    end
                end
                S_MUL: begin
                    r_cur_tgt <= rd_tgt;
                    if (r_total == '0) begin
                        r_share <= '0;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_share <= div_q;
                    end
                end
                S_CMP: begin
                    if (r_k == '0 || cand_better) begin
                        r_best_idx    <= r_idx;
                        r_best_share  <= r_share;
                        r_best_tgt    <= r_cur_tgt;
                        r_best_wanted <= cand_wanted;
                    end
                    r_k   <= r_k + USED_W'(1);
                    r_idx <= idx_wrap;
                end
                S_INC: begin
                    if (r_total != '1) begin
                        r_total <= r_total + COUNT_BITS'(1);
                    end
                    r_res_type <= rd_type;
                    r_res_hit  <= 1'b1;
                end
                S_LCMP: begin
                    if (rd_type == r_type) begin
                        r_res_hit <= 1'b1;
                    end
                    r_k   <= r_k + USED_W'(1);
                    r_idx <= r_idx + IDX_W'(1);
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_type  <= r_res_type;
                        r_out_hit   <= r_res_hit;
                        r_out_full  <= r_res_full;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    tss_table u_table (
        .i_clk      (i_clk),
        .i_ctl      (tbl_ctl),
        .i_wtype    (r_type),
        .i_wtgt     (tbl_wtgt),
        .i_wcount   (tbl_wcount),
        .o_rd_type  (rd_type),
        .o_rd_tgt   (rd_tgt),
        .o_rd_count (rd_count)
    );

    tss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (product),
        .i_divisor  (r_total),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.chosen_type = r_out_type;
    assign o_out.hit         = r_out_hit;
    assign o_out.table_full  = r_out_full;

endmodule

// ===== rtl/tss_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module tss_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tss_pkg::PROD_W-1:0]    i_dividend,
    input  logic [tss_pkg::COUNT_BITS-1:0] i_divisor,
    output logic                          o_done,
    output logic [tss_pkg::PROD_W-1:0]    o_quotient
);
    import tss_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DCNT_W-1:0]     r_cnt;
    logic [COUNT_BITS-1:0] r_rem;
    logic [PROD_W-1:0]     r_quo;
    logic [COUNT_BITS-1:0] r_dvs;

    logic [COUNT_BITS:0]   trial;
    logic [COUNT_BITS:0]   diff;
    logic                  ge;

    always_comb begin
        trial = {r_rem, r_quo[PROD_W-1]};
        ge    = trial >= {1'b0, r_dvs};
        diff  = trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // flag the cycle after the last quotient bit
            r_done <= !i_start && r_busy && (r_cnt == DCNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(PROD_W);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                // remainder stays below the divisor, so its low bits suffice
                r_rem <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
                r_quo <= {r_quo[PROD_W-2:0], ge};
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/tss_table.sv =====
// Entry table: type, target and pick count per entry, registered read.
module tss_table (
    input  logic                           i_clk,
    input  tss_pkg::t_tbl_ctl              i_ctl,
    input  logic [tss_pkg::TYPE_W-1:0]     i_wtype,
    input  logic [tss_pkg::TGT_W-1:0]      i_wtgt,
    input  logic [tss_pkg::COUNT_BITS-1:0] i_wcount,
    output logic [tss_pkg::TYPE_W-1:0]     o_rd_type,
    output logic [tss_pkg::TGT_W-1:0]      o_rd_tgt,
    output logic [tss_pkg::COUNT_BITS-1:0] o_rd_count
);
    import tss_pkg::*;

    logic [TYPE_W-1:0]     r_type_mem  [MAX_ENTRIES];
    logic [TGT_W-1:0]      r_tgt_mem   [MAX_ENTRIES];
    logic [COUNT_BITS-1:0] r_count_mem [MAX_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_ctl.we_entry) begin
            r_type_mem[i_ctl.waddr] <= i_wtype;
            r_tgt_mem[i_ctl.waddr]  <= i_wtgt;
        end
        if (i_ctl.we_entry || i_ctl.we_count) begin
            r_count_mem[i_ctl.waddr] <= i_wcount;
        end
        o_rd_type  <= r_type_mem[i_ctl.raddr];
        o_rd_tgt   <= r_tgt_mem[i_ctl.raddr];
        o_rd_count <= r_count_mem[i_ctl.raddr];
    end

endmodule

// ===== rtl/tss_checker.sv =====
// Port-level checks for the target share selector, bound to the top level.
module tss_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [tss_pkg::TYPE_W-1:0] i_out_chosen_type,
    input logic                       i_out_hit,
    input logic                       i_out_table_full
);
    import tss_pkg::*;

    // one command at a time: drop ready right after a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready stayed high after a command transaction");

    a_full_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_table_full |-> !i_out_hit && i_out_chosen_type == '0)
        else $error("dropped add reported a hit or a type");

    a_type_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_chosen_type != '0 |-> i_out_hit)
        else $error("type reported without hit");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_chosen_type)
            && $stable(i_out_hit) && $stable(i_out_table_full))
        else $error("stalled result changed");

endmodule

bind target_share_selector_top tss_checker u_tss_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_chosen_type (o_out.chosen_type),
    .i_out_hit         (o_out.hit),
    .i_out_table_full  (o_out.table_full)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for the target share selector: directed and random commands.
module testbench;
    import tss_pkg::*;

    // Random command count and run limit. The slowest correct run, with every
    // command a full pick over eight entries and the longest gap and stall,
    // stays near 4e6 time units. The limit takes that five times over.
    localparam int RANDOM_ITEMS = 1000;
    localparam int MAX_IDLE     = 6;
    localparam int RUN_LIMIT    = 20_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [TYPE_W-1:0] chosen_type;
        logic              hit;
        logic              table_full;
    } t_sel_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tss_in_if  cmd_if ();
    tss_out_if res_if ();

    target_share_selector_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the selector table, updated as each command is accepted.
    logic [TYPE_W-1:0]     tbl_type   [MAX_ENTRIES];
    logic [TGT_W-1:0]      tbl_target [MAX_ENTRIES];
    logic [COUNT_BITS-1:0] tbl_count  [MAX_ENTRIES];
    int                    tbl_used;
    logic [COUNT_BITS-1:0] pick_total;

    // Results still owed by the block, oldest first.
    t_sel_result pending_results [$];

    int  mismatch_count;
    int  cmds_sent;
    // Set during stretches where neither side inserts gaps or stalls.
    bit  steady_flow;
    // Small pool of types so that exists queries and duplicate adds hit often.
    logic [TYPE_W-1:0] type_pool [8];

    // Draw the idle cycles one side spends before its next transaction.
    function automatic int draw_idle();
        if (steady_flow)
            return 0;
        return $urandom_range(0, MAX_IDLE);
    endfunction

    // Achieved share of one entry in whole percent; zero count or zero total
    // gives a share of zero.
    function automatic longint unsigned share_pct(int idx);
        longint unsigned num;
        if (tbl_count[idx] == '0 || pick_total == '0)
            return 0;
        num = 64'(tbl_count[idx]) * 64'(PCT_SCALE);
        return num / 64'(pick_total);
    endfunction

    // An entry is under target when it has a target and its share has not
    // passed it.
    function automatic bit under_target(int idx, longint unsigned share);
        return tbl_target[idx] != '0 && share <= 64'(tbl_target[idx]);
    endfunction

    // True when entry a strictly beats entry b. Under-target entries come
    // first, then the lower share, then (among under-target) the higher target.
    // Anything else is a tie, so the earlier entry in the scan keeps the lead.
    function automatic bit outranks(int a, longint unsigned sa, int b, longint unsigned sb);
        bit wa;
        bit wb;
        wa = under_target(a, sa);
        wb = under_target(b, sb);
        if (wa != wb)
            return wa;
        if (sa != sb)
            return sa < sb;
        if (wa)
            return tbl_target[a] > tbl_target[b];
        return 1'b0;
    endfunction

    // Apply one accepted command to the shadow table and return its result.
    function automatic t_sel_result predict_selection(t_opcode op, logic [TYPE_W-1:0] typ,
                                                      logic [TGT_W-1:0] tgt,
                                                      logic [START_W-1:0] st);
        t_sel_result     res;
        int              n;
        int              k;
        int              idx;
        int              best;
        longint unsigned best_share;
        longint unsigned share;
        res = '0;
        case (op)
            OP_CLEAR: begin
                tbl_used   = 0;
                pick_total = '0;
            end
            OP_ADD: begin
                if (tbl_used >= MAX_ENTRIES) begin
                    res.table_full = 1'b1;
                end else begin
                    tbl_type[tbl_used]   = typ;
                    tbl_target[tbl_used] = (tgt > TGT_CLAMP) ? TGT_CLAMP : tgt;
                    tbl_count[tbl_used]  = '0;
                    tbl_used++;
                end
            end
            OP_PICK: begin
                if (tbl_used > 0) begin
                    n          = tbl_used;
                    best       = int'(st) % n;
                    best_share = share_pct(best);
                    // Scan from the tie start, wrapping round the used entries.
                    for (k = 1; k < n; k++) begin
                        idx   = (int'(st) + k) % n;
                        share = share_pct(idx);
                        if (outranks(idx, share, best, best_share)) begin
                            best       = idx;
                            best_share = share;
                        end
                    end
                    // Hold both counters at their maximum instead of wrapping.
                    if (tbl_count[best] != '1)
                        tbl_count[best]++;
                    if (pick_total != '1)
                        pick_total++;
                    res.chosen_type = tbl_type[best];
                    res.hit         = 1'b1;
                end
            end
            default: begin
                for (k = 0; k < tbl_used; k++) begin
                    if (tbl_type[k] == typ)
                        res.hit = 1'b1;
                end
            end
        endcase
        return res;
    endfunction

    // Send one command transaction. Raise valid right at the previous
    // acceptance edge when the gap is zero, so that valid never drops between
    // back-to-back transactions. Record the expected result at acceptance.
    task automatic send_cmd(t_opcode op, logic [TYPE_W-1:0] typ, logic [TGT_W-1:0] tgt,
                            logic [START_W-1:0] st);
        int gap;
        gap = draw_idle();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid          <= 1'b1;
        cmd_if.opcode         <= op;
        cmd_if.entry_type     <= typ;
        cmd_if.target_percent <= tgt;
        cmd_if.tie_start      <= st;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        pending_results.push_back(predict_selection(op, typ, tgt, st));
        cmds_sent++;
    endtask

    task automatic note_mismatch(string what, logic [TYPE_W-1:0] want_v,
                                 logic [TYPE_W-1:0] got_v);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want_v, got_v);
    endtask

    // Picks, queries and a clear on a table that holds nothing yet.
    task automatic test_empty_table();
        send_cmd(OP_PICK,   32'h0000_0000, 7'd0, 3'd7);
        send_cmd(OP_EXISTS, 32'h0000_0000, 7'd0, 3'd0);
        send_cmd(OP_CLEAR,  32'hFFFF_FFFF, 7'h7F, 3'd7);
    endtask

    // Field extremes, target clamp, duplicate types, full table, tie start
    // wrap, clear with picks after it, and adds made after picks.
    task automatic test_directed_table();
        send_cmd(OP_ADD,    32'hFFFF_FFFF, 7'd127, 3'd0);
        send_cmd(OP_ADD,    32'h0000_0000, 7'd0,   3'd7);
        // Zero total, so every share is zero; the targeted entry wins.
        send_cmd(OP_PICK,   32'h0000_0000, 7'd0,   3'd0);
        send_cmd(OP_PICK,   32'h0000_0000, 7'd0,   3'd5);
        send_cmd(OP_ADD,    32'h0000_0001, 7'd101, 3'd1);
        send_cmd(OP_ADD,    32'hFFFF_FFFF, 7'd1,   3'd2);
        send_cmd(OP_ADD,    32'h0000_0005, 7'd50,  3'd3);
        send_cmd(OP_ADD,    32'h0000_0006, 7'd0,   3'd4);
        send_cmd(OP_ADD,    32'h0000_0007, 7'd100, 3'd5);
        send_cmd(OP_ADD,    32'h0000_0008, 7'd25,  3'd6);
        // Table is full now; this add must be dropped.
        send_cmd(OP_ADD,    32'h0000_0009, 7'd1,   3'd7);
        send_cmd(OP_PICK,   32'h0000_0000, 7'd0,   3'd3);
        send_cmd(OP_PICK,   32'h0000_0000, 7'd0,   3'd7);
        send_cmd(OP_EXISTS, 32'hFFFF_FFFF, 7'd0,   3'd0);
        send_cmd(OP_EXISTS, 32'h0000_0000, 7'd0,   3'd0);
        send_cmd(OP_EXISTS, 32'h1234_5678, 7'd0,   3'd0);
        send_cmd(OP_CLEAR,  32'h0000_0000, 7'd0,   3'd0);
        send_cmd(OP_PICK,   32'h0000_0000, 7'd0,   3'd2);
        // Two untargeted entries: the first pick ties and settles by the tie start, the next goes to the lower share.
        send_cmd(OP_ADD,    32'hA5A5_A5A5, 7'd0,   3'd0);
        send_cmd(OP_ADD,    32'h5A5A_5A5A, 7'd0,   3'd0);
        send_cmd(OP_PICK,   32'h0000_0000, 7'd0,   3'd6);
        send_cmd(OP_PICK,   32'h0000_0000, 7'd0,   3'd1);
    endtask

    function automatic logic [TYPE_W-1:0] draw_type();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return type_pool[$urandom_range(0, 7)];
    endfunction

    // Mostly real percentages, plus no target, the top value and clamped values.
    function automatic logic [TGT_W-1:0] draw_target();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return TGT_W'($urandom_range(101, 127));
        if (r < 30)
            return TGT_W'(PCT_SCALE);
        return TGT_W'($urandom_range(1, 99));
    endfunction

    // Episodes of clear, a fill of one to ten adds, then a run of picks
    // mixed with queries, late adds and raw random commands.
    task automatic test_random_traffic();
        int first;
        int n_adds;
        int n_ops;
        int i;
        int r;
        first = cmds_sent;
        for (i = 0; i < 8; i++)
            type_pool[i] = $urandom;
        while (cmds_sent - first < RANDOM_ITEMS) begin
            // Switch between gapped and back-to-back traffic now and then.
            steady_flow = ($urandom_range(0, 3) == 0);
            send_cmd(OP_CLEAR, $urandom, TGT_W'($urandom), START_W'($urandom));
            n_adds = $urandom_range(1, 10);
            for (i = 0; i < n_adds; i++)
                send_cmd(OP_ADD, draw_type(), draw_target(), START_W'($urandom));
            n_ops = $urandom_range(5, 40);
            for (i = 0; i < n_ops; i++) begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    send_cmd(OP_PICK, $urandom, TGT_W'($urandom), START_W'($urandom));
                else if (r < 85)
                    send_cmd(OP_EXISTS, draw_type(), TGT_W'($urandom), START_W'($urandom));
                else if (r < 92)
                    send_cmd(OP_ADD, draw_type(), draw_target(), START_W'($urandom));
                else
                    send_cmd(t_opcode'($urandom_range(0, 3)), $urandom, TGT_W'($urandom),
                             START_W'($urandom));
            end
        end
        steady_flow = 1'b0;
    endtask

    // Result sink: stall ready at random, then compare each result transaction
    // with the oldest pending prediction.
    initial begin : result_monitor
        t_sel_result want;
        int          stall;
        res_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = draw_idle();
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result", '0, res_if.chosen_type);
            end else begin
                want = pending_results.pop_front();
                if (res_if.chosen_type !== want.chosen_type)
                    note_mismatch("chosen_type", want.chosen_type, res_if.chosen_type);
                if (res_if.hit !== want.hit)
                    note_mismatch("hit", TYPE_W'(want.hit), TYPE_W'(res_if.hit));
                if (res_if.table_full !== want.table_full)
                    note_mismatch("table_full", TYPE_W'(want.table_full),
                                  TYPE_W'(res_if.table_full));
            end
        end
    end

    // Main sequence: reset once, run the tests, drain, report.
    initial begin
        mismatch_count = 0;
        cmds_sent      = 0;
        steady_flow    = 1'b0;
        tbl_used       = 0;
        pick_total     = '0;
        i_rst_n               <= 1'b0;
        cmd_if.valid          <= 1'b0;
        cmd_if.opcode         <= OP_CLEAR;
        cmd_if.entry_type     <= '0;
        cmd_if.target_percent <= '0;
        cmd_if.tie_start      <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_directed_table();
        test_random_traffic();

        cmd_if.valid <= 1'b0;
        // Wait for every owed result, then a few idle cycles to catch extras.
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // Timeout guard; a hung handshake or missing result ends up here.
    initial begin
        #RUN_LIMIT;
        $display("testbench failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tss_pkg.sv
rtl/tss_if.sv
rtl/tss_div.sv
rtl/tss_table.sv
rtl/target_share_selector_top.sv
rtl/tss_checker.sv
sim/testbench.sv
